[src/esl_pkg.sv]
`default_nettype none
package esl_pkg;

    localparam int VEL_W   = 24;
    localparam int POS_W   = 32;
    localparam int DIST_W  = 16;
    localparam int FLOOR_W = 23;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // Quotient of the ramp is below 2^23, so the divider resolves 23 bits.
    localparam int DIV_STEPS = 23;
    localparam int NUM_W     = VEL_W + DIST_W;
    localparam int FRONT_LAT = 3;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_STEPS + 1;

    localparam logic [IDX_W-1:0] REG_MIN_LIMIT     = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_LIMIT     = 3'd1;
    localparam logic [IDX_W-1:0] REG_STOP_DISTANCE = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOW_DISTANCE = 3'd3;
    localparam logic [IDX_W-1:0] REG_FLOOR_SPEED   = 3'd4;

    typedef enum logic [1:0] {
        ST_PASS = 2'd0,
        ST_STOP = 2'd1,
        ST_SLOW = 2'd2,
        ST_ZERO = 2'd3
    } esl_status_t;

    typedef struct packed {
        logic [POS_W-1:0]   min_limit;
        logic [POS_W-1:0]   max_limit;
        logic [DIST_W-1:0]  stop_distance;
        logic [DIST_W-1:0]  slow_distance;
        logic [FLOOR_W-1:0] floor_speed;
    } esl_cfg_t;

    // Travels beside the numerator through the divider.
    typedef struct packed {
        logic [VEL_W-1:0] vel;
        logic             up;
        logic             floor_ge;
        esl_status_t      status;
    } esl_side_t;

endpackage
`default_nettype wire

[src/edge_speed_limiter_unit.sv]
`default_nettype none
// Soft-limit speed shaper for one axis. Pulse start with a signed Q15.8
// velocity and the axis position; busy never rises, so a new sample may be
// started every clock. Each sample yields exactly one result, shown for one
// cycle with result_valid. Front stages A, B and C classify the sample and
// form the ramp numerator, the bit-per-stage pipelined divider scales the
// ramp, and one output register holds the result. The result cannot be
// held off. Write the limit registers through cfg_we, cfg_index and
// cfg_data only while no sample is in flight.
module edge_speed_limiter_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [esl_pkg::VEL_W-1:0]    velocity,
    input  wire logic [esl_pkg::POS_W-1:0]    position,
    output logic                              result_valid,
    output logic [esl_pkg::VEL_W-1:0]         limited_velocity,
    output logic [1:0]                        limit_status,
    input  wire logic                         cfg_we,
    input  wire logic [esl_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [esl_pkg::CFG_W-1:0]    cfg_data
);
    import esl_pkg::*;

    esl_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LIMIT:     cfg_reg.min_limit     <= cfg_data;
                REG_MAX_LIMIT:     cfg_reg.max_limit     <= cfg_data;
                REG_STOP_DISTANCE: cfg_reg.stop_distance <= cfg_data[DIST_W-1:0];
                REG_SLOW_DISTANCE: cfg_reg.slow_distance <= cfg_data[DIST_W-1:0];
                REG_FLOOR_SPEED:   cfg_reg.floor_speed   <= cfg_data[FLOOR_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    logic                 in_valid;
    logic                 num_valid;
    logic [NUM_W-1:0]     num;
    esl_side_t            num_side;
    logic                 quo_valid;
    logic [DIV_STEPS-1:0] quo;
    esl_side_t            quo_side;
    logic [DIST_W-1:0]    span;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;
    assign span     = cfg_reg.slow_distance - cfg_reg.stop_distance;

    esl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .velocity  (velocity),
        .position  (position),
        .num_valid (num_valid),
        .num       (num),
        .side      (num_side)
    );

    esl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .span      (span),
        .num_valid (num_valid),
        .num       (num),
        .num_side  (num_side),
        .quo_valid (quo_valid),
        .quo       (quo),
        .quo_side  (quo_side)
    );

    logic [VEL_W-1:0] mag;
    logic [VEL_W-1:0] slow_vel;
    logic [VEL_W-1:0] res_next;

    logic             result_valid_reg;
    logic [VEL_W-1:0] limited_velocity_reg;
    logic [1:0]       limit_status_reg;

    always_comb
    begin
        // floor at or above the command wins outright; otherwise the ramp
        // stays between floor and command by construction
        if (quo_side.floor_ge)
        begin
            mag = {1'b0, cfg_reg.floor_speed};
        end
        else
        begin
            mag = {1'b0, cfg_reg.floor_speed} + {1'b0, quo};
        end
        slow_vel = quo_side.up ? mag : (VEL_W'(0) - mag);
        case (quo_side.status)
            ST_PASS: res_next = quo_side.vel;
            ST_SLOW: res_next = slow_vel;
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= quo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        limited_velocity_reg <= res_next;
        limit_status_reg     <= quo_side.status;
    end

    assign result_valid     = result_valid_reg;
    assign limited_velocity = limited_velocity_reg;
    assign limit_status     = limit_status_reg;

    a_start_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT result_valid)
        else $error("accepted sample produced no result");

    a_result_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching start");

    a_pass_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (limit_status == ST_PASS)) |->
            (limited_velocity == $past(velocity, PIPE_LAT)))
        else $error("unchanged status but velocity altered");

endmodule
`default_nettype wire

[src/esl_front.sv]
`default_nettype none
module esl_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire esl_pkg::esl_cfg_t          cfg,
    input  wire logic                       in_valid,
    input  wire logic [esl_pkg::VEL_W-1:0]  velocity,
    input  wire logic [esl_pkg::POS_W-1:0]  position,
    output logic                            num_valid,
    output logic [esl_pkg::NUM_W-1:0]       num,
    output esl_pkg::esl_side_t              side
);
    import esl_pkg::*;

    // stage A: direction, magnitude, distance to the limit ahead
    logic                 a_valid_reg;
    logic                 a_zero_reg;
    logic                 a_up_reg;
    logic [VEL_W-1:0]     a_av_reg;
    logic [POS_W:0]       a_d_reg;
    logic [VEL_W-1:0]     a_vel_reg;

    logic                 a_up_next;
    logic [VEL_W-1:0]     a_av_next;
    logic [POS_W:0]       a_d_next;
    logic [POS_W:0]       pos_x;

    always_comb
    begin
        pos_x     = {position[POS_W-1], position};
        a_up_next = ~velocity[VEL_W-1];
        a_av_next = a_up_next ? velocity : (VEL_W'(0) - velocity);
        if (a_up_next)
        begin
            a_d_next = {cfg.max_limit[POS_W-1], cfg.max_limit} - pos_x;
        end
        else
        begin
            a_d_next = pos_x - {cfg.min_limit[POS_W-1], cfg.min_limit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_zero_reg <= (velocity == '0);
        a_up_reg   <= a_up_next;
        a_av_reg   <= a_av_next;
        a_d_reg    <= a_d_next;
        a_vel_reg  <= velocity;
    end

    // stage B: classify and form the ramp operands
    logic                 b_valid_reg;
    esl_side_t            b_side_reg;
    logic [VEL_W-1:0]     b_diff_reg;
    logic [DIST_W-1:0]    b_n_reg;

    esl_side_t            b_side_next;
    logic                 d_nonpos;
    logic                 d_le_stop;
    logic                 d_lt_slow;

    always_comb
    begin
        d_nonpos  = a_d_reg[POS_W] || (a_d_reg == '0);
        d_le_stop = $signed(a_d_reg) <= $signed({{(POS_W+1-DIST_W){1'b0}}, cfg.stop_distance});
        d_lt_slow = $signed(a_d_reg) <  $signed({{(POS_W+1-DIST_W){1'b0}}, cfg.slow_distance});

        b_side_next.vel      = a_vel_reg;
        b_side_next.up       = a_up_reg;
        b_side_next.floor_ge = {1'b0, cfg.floor_speed} >= a_av_reg;
        if (a_zero_reg)
        begin
            b_side_next.status = ST_ZERO;
        end
        else if (d_nonpos || d_le_stop)
        begin
            b_side_next.status = ST_STOP;
        end
        else if (d_lt_slow)
        begin
            b_side_next.status = ST_SLOW;
        end
        else
        begin
            b_side_next.status = ST_PASS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= b_side_next;
        // only meaningful inside the slow zone with floor below command
        b_diff_reg <= a_av_reg - {1'b0, cfg.floor_speed};
        b_n_reg    <= a_d_reg[DIST_W-1:0] - cfg.stop_distance;
    end

    // stage C: numerator of the ramp
    logic                 c_valid_reg;
    esl_side_t            c_side_reg;
    logic [NUM_W-1:0]     c_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_side_reg <= b_side_reg;
        c_prod_reg <= b_diff_reg * b_n_reg;
    end

    assign num_valid = c_valid_reg;
    assign num       = c_prod_reg;
    assign side      = c_side_reg;

endmodule
`default_nettype wire

[src/esl_div.sv]
`default_nettype none
module esl_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [esl_pkg::DIST_W-1:0]    span,
    input  wire logic                          num_valid,
    input  wire logic [esl_pkg::NUM_W-1:0]     num,
    input  wire esl_pkg::esl_side_t            num_side,
    output logic                               quo_valid,
    output logic [esl_pkg::DIV_STEPS-1:0]      quo,
    output esl_pkg::esl_side_t                 quo_side
);
    import esl_pkg::*;

    // one quotient bit per stage; work holds the dividend bits still to
    // shift in, with quotient bits filling from the bottom
    logic                  valid_reg [DIV_STEPS];
    logic [DIST_W-1:0]     rem_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0]  work_reg  [DIV_STEPS];
    esl_side_t             side_reg  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic                 valid_in;
        logic [DIST_W-1:0]    rem_in;
        logic [DIV_STEPS-1:0] work_in;
        esl_side_t            side_in;
        logic [DIST_W:0]      trial;
        logic [DIST_W:0]      trial_sub;
        logic                 ge;

        if (k == 0)
        begin : g_head
            // numerator stays below span * 2^23, so its top bit is clear
            assign valid_in = num_valid;
            assign rem_in   = num[NUM_W-2:DIV_STEPS];
            assign work_in  = num[DIV_STEPS-1:0];
            assign side_in  = num_side;
        end
        else
        begin : g_body
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign work_in  = work_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        always_comb
        begin
            trial     = {rem_in, work_in[DIV_STEPS-1]};
            trial_sub = trial - {1'b0, span};
            ge        = trial >= {1'b0, span};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? trial_sub[DIST_W-1:0] : trial[DIST_W-1:0];
            work_reg[k] <= {work_in[DIV_STEPS-2:0], ge};
            side_reg[k] <= side_in;
        end
    end

    assign quo_valid = valid_reg[DIV_STEPS-1];
    assign quo       = work_reg[DIV_STEPS-1];
    assign quo_side  = side_reg[DIV_STEPS-1];

endmodule
`default_nettype wire
